// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mtp_pkg.sv =====
// Package with widths and types of the triangle perimeter maximum block.
`default_nettype none
package mtp_pkg;
  localparam int COORD_BITS = 24;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int ROOT_BITS  = COORD_BITS + 1;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int PSUM_BITS  = ROOT_BITS + 2;
  localparam int PERIM_BITS = 27;
  localparam int CMP_BITS   = PSUM_BITS + PERIM_BITS;
  localparam int STEP_BITS  = $clog2(ROOT_BITS);
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = 2;
  localparam int QCNT_BITS  = 3;

  typedef struct packed {
    logic [2:0][SUM_BITS-1:0] sums;
    logic                     last;
  } tri_sums_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mtp_front.sv =====
// Front end: edge differences, squares and squared-length sums per triangle.
`default_nettype none
module mtp_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [2:0][2:0][mtp_pkg::COORD_BITS-1:0] pts,
  input  wire logic                                  last_in,
  input  wire logic                                  q_pop,
  output logic                                       q_push,
  output mtp_pkg::tri_sums_t                         q_wdata
);
  logic [2:0][2:0][mtp_pkg::COORD_BITS-1:0] mag_nxt, mag_r;
  logic [2:0][2:0][mtp_pkg::SQ_BITS-1:0]    sq_r;
  logic [2:0][2:0][mtp_pkg::COORD_BITS:0]   diff;
  logic [2:0][2:0][mtp_pkg::COORD_BITS:0]   absd;
  logic                                     va_r, vb_r, la_r, lb_r;
  logic [mtp_pkg::QCNT_BITS-1:0]            inflight_r, inflight_nxt;
  logic                                     accept;

  // Edge 0 is AB, edge 1 is AC, edge 2 is BC.
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        if (e == 0) begin
          diff[e][k] = {pts[1][k][mtp_pkg::COORD_BITS-1], pts[1][k]}
                     - {pts[0][k][mtp_pkg::COORD_BITS-1], pts[0][k]};
        end else if (e == 1) begin
          diff[e][k] = {pts[2][k][mtp_pkg::COORD_BITS-1], pts[2][k]}
                     - {pts[0][k][mtp_pkg::COORD_BITS-1], pts[0][k]};
        end else begin
          diff[e][k] = {pts[2][k][mtp_pkg::COORD_BITS-1], pts[2][k]}
                     - {pts[1][k][mtp_pkg::COORD_BITS-1], pts[1][k]};
        end
        absd[e][k] = diff[e][k][mtp_pkg::COORD_BITS] ? (~diff[e][k] + 1'b1) : diff[e][k];
        mag_nxt[e][k] = absd[e][k][mtp_pkg::COORD_BITS-1:0];
      end
    end
  end

  assign accept   = in_valid && !in_stall;
  // Credits cover both pipeline stages and the queue, so the pipeline never stalls.
  assign in_stall = (inflight_r == mtp_pkg::QCNT_BITS'(mtp_pkg::QDEPTH));
  assign inflight_nxt = inflight_r + mtp_pkg::QCNT_BITS'(accept)
                      - mtp_pkg::QCNT_BITS'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      inflight_r <= '0;
    end else begin
      va_r       <= accept;
      vb_r       <= va_r;
      inflight_r <= inflight_nxt;
    end
    mag_r <= mag_nxt;
    la_r  <= last_in;
    lb_r  <= la_r;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[e][k] <= mag_r[e][k] * mag_r[e][k];
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      q_wdata.sums[e] = mtp_pkg::SUM_BITS'(sq_r[e][0]) + mtp_pkg::SUM_BITS'(sq_r[e][1])
                      + mtp_pkg::SUM_BITS'(sq_r[e][2]);
    end
    q_wdata.last = lb_r;
  end
  assign q_push = vb_r;
endmodule
`default_nettype wire

// ===== hw/rtl/mtp_queue.sv =====
// Short queue between the front end and the square-root back end.
`default_nettype none
module mtp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mtp_pkg::tri_sums_t wdata,
  input  wire logic               pop,
  output logic                    q_valid,
  output mtp_pkg::tri_sums_t      rdata
);
  mtp_pkg::tri_sums_t             mem [mtp_pkg::QDEPTH];
  logic [mtp_pkg::QPTR_BITS-1:0]  wr_r, rd_r;
  logic [mtp_pkg::QCNT_BITS-1:0]  cnt_r;

  assign q_valid = (cnt_r != '0);
  assign rdata   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + mtp_pkg::QCNT_BITS'(push) - mtp_pkg::QCNT_BITS'(pop);
    end
    if (push) begin
      mem[wr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mtp_back.sv =====
// Back end: three bit-serial square roots, perimeter sum and running maximum.
`default_nettype none
module mtp_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire mtp_pkg::tri_sums_t              q_rdata,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mtp_pkg::PERIM_BITS-1:0]       out_max_perimeter
);
  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_SUM, S_DONE} state_t;

  state_t                                  state_r;
  logic [2:0][mtp_pkg::SUM_BITS-1:0]       rad_r;
  logic [2:0][mtp_pkg::REM_BITS-1:0]       rem_r, rem_nxt;
  logic [2:0][mtp_pkg::ROOT_BITS-1:0]      root_r, root_nxt;
  logic [2:0][mtp_pkg::REM_BITS+1:0]       rem_ext, trial;
  logic [2:0]                              ge;
  logic [mtp_pkg::STEP_BITS-1:0]           step_r;
  logic                                    last_r;
  logic [mtp_pkg::PSUM_BITS-1:0]           perim_r;
  logic [mtp_pkg::PERIM_BITS-1:0]          max_r, max_nxt;
  logic                                    out_valid_r;
  logic [mtp_pkg::PERIM_BITS-1:0]          out_data_r;
  logic                                    out_fire;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_ext[i]  = {rem_r[i], rad_r[i][mtp_pkg::SUM_BITS-1 -: 2]};
      trial[i]    = {2'b00, root_r[i], 2'b01};
      ge[i]       = (rem_ext[i] >= trial[i]);
      rem_nxt[i]  = ge[i] ? mtp_pkg::REM_BITS'(rem_ext[i] - trial[i])
                          : mtp_pkg::REM_BITS'(rem_ext[i]);
      root_nxt[i] = {root_r[i][mtp_pkg::ROOT_BITS-2:0], ge[i]};
    end
    if (mtp_pkg::CMP_BITS'(perim_r) > mtp_pkg::CMP_BITS'(max_r)) begin
      max_nxt = mtp_pkg::PERIM_BITS'(perim_r);
    end else begin
      max_nxt = max_r;
    end
  end

  // A finished set loads the output register once it is free or being taken.
  assign out_fire          = (state_r == S_DONE) && last_r && (!out_valid_r || !out_stall);
  assign q_pop             = (state_r == S_IDLE) && q_valid;
  assign out_valid         = out_valid_r;
  assign out_max_perimeter = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (step_r == '0) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!last_r) begin
            max_r   <= max_nxt;
            state_r <= S_IDLE;
          end else if (out_fire) begin
            out_data_r  <= max_nxt;
            max_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    case (state_r)
      S_IDLE: begin
        rad_r  <= q_rdata.sums;
        last_r <= q_rdata.last;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= mtp_pkg::STEP_BITS'(mtp_pkg::ROOT_BITS - 1);
      end
      S_ROOT: begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        for (int i = 0; i < 3; i++) begin
          rad_r[i] <= {rad_r[i][mtp_pkg::SUM_BITS-3:0], 2'b00};
        end
        step_r <= step_r - 1'b1;
      end
      S_SUM: begin
        perim_r <= mtp_pkg::PSUM_BITS'(root_r[0]) + mtp_pkg::PSUM_BITS'(root_r[1])
                 + mtp_pkg::PSUM_BITS'(root_r[2]);
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/max_triangle_perimeter_3d.sv =====
// Top level of the largest triangle perimeter block.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_stall    nine Q16.8 coordinates, last_triangle
//  out_     output     out_valid/out_stall  max_perimeter, unsigned Q.8
//
// A transaction on the input channel takes one triangle. The front end turns it, via
// its magnitude and square registers, into three squared edge lengths in a four-entry
// queue. The back end runs three bit-serial square roots side by side, one result bit
// per cycle, and takes a new triangle only once done with the last; it sets the rate.
// Reset is synchronous and clears the running maximum, the queue and the output valid.
// Input stall rises only when four triangles are in flight; the output register lets
// the back end keep working while a result waits, until the next result is ready.
`default_nettype none
module max_triangle_perimeter_3d (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_ax,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_ay,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_az,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_bx,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_by_coord,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_bz,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_cx,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_cy,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_cz,
  input  wire logic                                 in_last_triangle,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [mtp_pkg::PERIM_BITS-1:0]            out_max_perimeter
);
  logic [2:0][2:0][mtp_pkg::COORD_BITS-1:0] pts;
  logic                                     q_push, q_pop, q_valid;
  mtp_pkg::tri_sums_t                       q_wdata, q_rdata;

  // Vertex A, B, C by row; x, y, z by column.
  always_comb begin
    pts[0][0] = in_ax;
    pts[0][1] = in_ay;
    pts[0][2] = in_az;
    pts[1][0] = in_bx;
    pts[1][1] = in_by_coord;
    pts[1][2] = in_bz;
    pts[2][0] = in_cx;
    pts[2][1] = in_cy;
    pts[2][2] = in_cz;
  end

  mtp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pts      (pts),
    .last_in  (in_last_triangle),
    .q_pop    (q_pop),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mtp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  mtp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_max_perimeter (out_max_perimeter)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/mtp_checker.sv =====
// Port-level checker for the largest triangle perimeter block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module mtp_port_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [mtp_pkg::PERIM_BITS-1:0]    out_max_perimeter
);
  `MTP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `MTP_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_max_perimeter), "stalled result changed")
  `MTP_ASSERT(a_out_range, out_valid |-> out_max_perimeter <= 27'd87176970, "perimeter out of range")
  `MTP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result present after reset")
endmodule

bind max_triangle_perimeter_3d mtp_port_checker u_mtp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_max_perimeter (out_max_perimeter)
);
`default_nettype wire

// ===== dv/mtp_checker.sv =====
// Checker that predicts the largest triangle perimeter per set and compares results.
`default_nettype none
module mtp_checker (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic                                  in_stall,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_ax,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_ay,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_az,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_bx,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_by_coord,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_bz,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_cx,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_cy,
  input  wire logic signed [mtp_pkg::COORD_BITS-1:0] in_cz,
  input  wire logic                                  in_last_triangle,
  input  wire logic                                  out_valid,
  input  wire logic                                  out_stall,
  input  wire logic [mtp_pkg::PERIM_BITS-1:0]        out_max_perimeter,
  output int                                         fail_count,
  output int                                         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [mtp_pkg::PERIM_BITS-1:0] set_max;
  logic [mtp_pkg::PERIM_BITS-1:0] max_queue[$];

  function automatic logic [63:0] isqrt_floor(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] edge_length(input longint px, py, pz, qx, qy, qz);
    longint dx, dy, dz;
    dx = qx - px;
    dy = qy - py;
    dz = qz - pz;
    return isqrt_floor(dx * dx + dy * dy + dz * dz);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [63:0] perim;
    if (!rst_n) begin
      set_max = 0;
      max_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (max_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_max_perimeter));
        end else begin
          if (out_max_perimeter !== max_queue[0])
            report_mismatch($sformatf("max_perimeter got %0d expected %0d",
                                      out_max_perimeter, max_queue[0]));
          void'(max_queue.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        perim = edge_length(in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz)
              + edge_length(in_ax, in_ay, in_az, in_cx, in_cy, in_cz)
              + edge_length(in_bx, in_by_coord, in_bz, in_cx, in_cy, in_cz);
        if (perim > 64'(set_max)) set_max = perim[mtp_pkg::PERIM_BITS-1:0];
        if (in_last_triangle) begin
          max_queue.push_back(set_max);
          set_max = 0;
        end
      end
    end
    pending_count = max_queue.size();
  end
endmodule
`default_nettype wire

// ===== dv/max_triangle_perimeter_3d_tb.sv =====
// Testbench top that drives triangles into the perimeter block and gives the verdict.
`default_nettype none
module max_triangle_perimeter_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = mtp_pkg::COORD_BITS;
  localparam int IDLE_LIMIT = 20000;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] crd[9];
  logic in_last_triangle = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mtp_pkg::PERIM_BITS-1:0] out_max_perimeter;
  int fail_count;
  int pending_count;

  // Idle rates in percent for the sender and receiver; changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // While set, the receiver stalls for a long stretch so the block backs up.
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  initial for (int i = 0; i < 9; i++) crd[i] = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  max_triangle_perimeter_3d u_top (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_ax(crd[0]), .in_ay(crd[1]), .in_az(crd[2]),
    .in_bx(crd[3]), .in_by_coord(crd[4]), .in_bz(crd[5]),
    .in_cx(crd[6]), .in_cy(crd[7]), .in_cz(crd[8]),
    .in_last_triangle, .out_valid, .out_stall, .out_max_perimeter
  );

  mtp_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_ax(crd[0]), .in_ay(crd[1]), .in_az(crd[2]),
    .in_bx(crd[3]), .in_by_coord(crd[4]), .in_bz(crd[5]),
    .in_cx(crd[6]), .in_cy(crd[7]), .in_cz(crd[8]),
    .in_last_triangle, .out_valid, .out_stall, .out_max_perimeter,
    .fail_count, .pending_count
  );

  // The receiver decides its stall at every falling edge, so the value is stable
  // well before the rising edge where the block samples it.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // The watchdog counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one triangle: optional idle gaps first, then valid is held until accepted.
  task automatic send_triangle(input logic signed [CW-1:0] v[9], input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 9; i++) crd[i] <= v[i];
    in_last_triangle <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Random coordinate; small spreads are common so the square roots see all sizes.
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(4))
      0: return CW'($urandom);
      1: return ($urandom_range(1)) ? CMAX : CMIN;
      2: return CW'($signed($urandom_range(512)) - 256);
      default: return CW'($signed($urandom_range(65536)) - 32768);
    endcase
  endfunction

  task automatic send_random_sets(input int count);
    logic signed [CW-1:0] v[9];
    int sent;
    sent = 0;
    while (sent < count) begin
      int set_len;
      set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int t = 0; t < set_len; t++) begin
        for (int i = 0; i < 9; i++) v[i] = rand_coord();
        // Sometimes reuse a vertex to make degenerate triangles.
        if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) v[3 + i] = v[i];
        send_triangle(v, t == set_len - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    logic signed [CW-1:0] v[9];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: all-zero triangle, extreme corners, a repeated maximum,
    // a collinear triangle, and a set whose later triangle is smaller.
    for (int i = 0; i < 9; i++) v[i] = '0;
    send_triangle(v, 1'b1);
    v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN};
    send_triangle(v, 1'b0);
    send_triangle(v, 1'b1);
    v = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN};
    send_triangle(v, 1'b1);
    v = '{0, 0, 0, 256, 256, 256, 512, 512, 512};
    send_triangle(v, 1'b0);
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_triangle(v, 1'b1);
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_triangle(v, 1'b1);
    v = '{CMAX, 0, 0, CMIN, 0, 0, 0, CMAX, CMIN};
    send_triangle(v, 1'b0);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(v, 1'b1);
    in_valid <= 1'b0;

    // Back-pressure: the receiver holds off while the sender keeps offering.
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      send_random_sets(40);
    join

    send_idle_pct = 31;
    recv_idle_pct = 64;
    send_random_sets(500);
    send_idle_pct = 64;
    recv_idle_pct = 31;
    send_random_sets(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_sets(500);

    wait_drained();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== max_triangle_perimeter_3d.f =====
+incdir+hw/rtl
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_front.sv
hw/rtl/mtp_queue.sv
hw/rtl/mtp_back.sv
hw/rtl/max_triangle_perimeter_3d.sv
hw/rtl/mtp_checker.sv
dv/mtp_checker.sv
dv/max_triangle_perimeter_3d_tb.sv
